>>> src/tpq_pkg.sv
package tpq_pkg;

    localparam int unsigned CoordBits = 12;
    localparam int unsigned CfgIdxBits = 3;
    localparam int unsigned CfgDataBits = CoordBits;
    localparam int unsigned WeightBits = 20;
    localparam int unsigned AreaBits = 25;

    localparam logic [CfgIdxBits-1:0] REG_V0X = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_V0Y = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_V1X = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_V1Y = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_V2X = 3'd4;
    localparam logic [CfgIdxBits-1:0] REG_V2Y = 3'd5;

    typedef struct packed {
        logic signed [CoordBits-1:0] query_x;
        logic signed [CoordBits-1:0] query_y;
    } t_in_item;

    typedef struct packed {
        logic                         inside_res;
        logic signed [WeightBits-1:0] weight_first;
        logic signed [WeightBits-1:0] weight_second;
        logic signed [WeightBits-1:0] weight_third;
        logic        [AreaBits-1:0]   double_area;
        logic                         degenerate;
    } t_out_item;

endpackage

>>> src/tpq_div_cell.sv
module tpq_div_cell #(
    parameter int unsigned NB = 32,
    parameter int unsigned DB = 26,
    parameter int unsigned SB = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NB-1:0] i_rem,
    input  logic [NB-1:0] i_num,
    input  logic [DB-1:0] i_den,
    input  logic [SB-1:0] i_side,
    output logic [NB-1:0] o_rem,
    output logic [NB-1:0] o_num,
    output logic [DB-1:0] o_den,
    output logic [SB-1:0] o_side
);

    logic [NB:0]   n_trial;
    logic [NB-1:0] n_shift;
    logic [NB-1:0] r_rem;
    logic [NB-1:0] r_num;
    logic [DB-1:0] r_den;
    logic [SB-1:0] r_side;

    always_comb begin
        n_shift = {i_rem[NB-2:0], i_num[NB-1]};
        n_trial = {1'b0, n_shift} - {{(NB+1-DB){1'b0}}, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den  <= i_den;
            r_side <= i_side;
            if (!n_trial[NB]) begin
                r_rem <= n_trial[NB-1:0];
                r_num <= {i_num[NB-2:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_num <= {i_num[NB-2:0], 1'b0};
            end
        end
    end

    assign o_rem  = r_rem;
    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_side = r_side;

endmodule

>>> src/triangle_point_query.sv
// Triangle point query: inside test, barycentric weights and twice the area
// of a triangle whose vertices sit in six configuration registers.
// Write the vertices through i_cfg_we/i_cfg_idx/i_cfg_data while idle;
// indices beyond the sixth register are ignored.
// Input channel: i_in_valid/o_in_stall carry one query point per item.
// Output channel: o_out_valid/i_out_stall carry one result item per query.
// Throughput is one item per cycle while the output is not stalled. Each query
// is registered through the difference, product and cross stages, a chain of
// NUM_BITS = 2*CoordBits+FRAC_BITS+2 restoring divider cells, one quotient bit
// per cell, that the two weights run through side by side, and an output stage.
// The whole pipe advances together; while the output is stalled with a
// result waiting, the pipe holds and o_in_stall rises.
// Synchronous reset empties the pipe and clears all vertices to zero.
module triangle_point_query #(
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tpq_pkg::CfgIdxBits-1:0]   i_cfg_idx,
    input  logic [tpq_pkg::CfgDataBits-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tpq_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tpq_pkg::t_out_item               o_out_item
);

    localparam int unsigned CB  = tpq_pkg::CoordBits;
    localparam int unsigned DB  = 2*CB + 2;
    localparam int unsigned NB  = 2*CB + FRAC_BITS + 2;
    localparam int unsigned WB  = tpq_pkg::WeightBits;
    localparam int unsigned AB  = tpq_pkg::AreaBits;
    localparam int unsigned SB  = 6;
    localparam int unsigned LAT = NB + 4;

    logic signed [CB-1:0] r_vx [3];
    logic signed [CB-1:0] r_vy [3];
    logic [LAT-1:0] r_vld;
    logic adv;
    logic signed [CB-1:0] qx, qy;

    assign adv = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall = !adv;
    assign o_out_valid = r_vld[LAT-1];
    assign qx = i_in_item.query_x;
    assign qy = i_in_item.query_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int k = 0; k < 3; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
            end
        end else begin
            if (adv) r_vld <= {r_vld[LAT-2:0], i_in_valid};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tpq_pkg::REG_V0X: r_vx[0] <= CB'(i_cfg_data);
                    tpq_pkg::REG_V0Y: r_vy[0] <= CB'(i_cfg_data);
                    tpq_pkg::REG_V1X: r_vx[1] <= CB'(i_cfg_data);
                    tpq_pkg::REG_V1Y: r_vy[1] <= CB'(i_cfg_data);
                    tpq_pkg::REG_V2X: r_vx[2] <= CB'(i_cfg_data);
                    tpq_pkg::REG_V2Y: r_vy[2] <= CB'(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // stage 1: differences
    logic signed [CB:0] r_v0x, r_v0y, r_v1x, r_v1y, r_v2x, r_v2y;
    logic signed [CB:0] r_e1x, r_e1y, r_q1x, r_q1y, r_e2x, r_e2y, r_q2x, r_q2y;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_v0x <= (CB+1)'(r_vx[1]) - (CB+1)'(r_vx[0]);
            r_v0y <= (CB+1)'(r_vy[1]) - (CB+1)'(r_vy[0]);
            r_v1x <= (CB+1)'(r_vx[2]) - (CB+1)'(r_vx[0]);
            r_v1y <= (CB+1)'(r_vy[2]) - (CB+1)'(r_vy[0]);
            r_v2x <= (CB+1)'(qx) - (CB+1)'(r_vx[0]);
            r_v2y <= (CB+1)'(qy) - (CB+1)'(r_vy[0]);
            r_e1x <= (CB+1)'(r_vx[2]) - (CB+1)'(r_vx[1]);
            r_e1y <= (CB+1)'(r_vy[2]) - (CB+1)'(r_vy[1]);
            r_q1x <= (CB+1)'(qx) - (CB+1)'(r_vx[1]);
            r_q1y <= (CB+1)'(qy) - (CB+1)'(r_vy[1]);
            r_e2x <= (CB+1)'(r_vx[0]) - (CB+1)'(r_vx[2]);
            r_e2y <= (CB+1)'(r_vy[0]) - (CB+1)'(r_vy[2]);
            r_q2x <= (CB+1)'(qx) - (CB+1)'(r_vx[2]);
            r_q2y <= (CB+1)'(qy) - (CB+1)'(r_vy[2]);
        end
    end

    // stage 2: products
    logic signed [DB-1:0] r_p [10];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p[0] <= DB'(r_v0x * r_v1y);
            r_p[1] <= DB'(r_v0y * r_v1x);
            r_p[2] <= DB'(r_v2x * r_v1y);
            r_p[3] <= DB'(r_v2y * r_v1x);
            r_p[4] <= DB'(r_v0x * r_v2y);
            r_p[5] <= DB'(r_v0y * r_v2x);
            r_p[6] <= DB'(r_e1x * r_q1y);
            r_p[7] <= DB'(r_e1y * r_q1x);
            r_p[8] <= DB'(r_e2x * r_q2y);
            r_p[9] <= DB'(r_e2y * r_q2x);
        end
    end

    // stage 3: crosses, signs, magnitudes
    logic signed [DB-1:0] c, a1, a2, o12, o20;
    assign c   = r_p[0] - r_p[1];
    assign a1  = r_p[2] - r_p[3];
    assign a2  = r_p[4] - r_p[5];
    assign o12 = r_p[6] - r_p[7];
    assign o20 = r_p[8] - r_p[9];

    function automatic logic sign_ok(logic signed [DB-1:0] o, logic signed [DB-1:0] t);
        logic oz, tz;
        begin
            oz = (o == '0);
            tz = (t == '0);
            sign_ok = oz || (!tz && (o[DB-1] == t[DB-1]));
        end
    endfunction

    function automatic logic [DB-1:0] mag(logic signed [DB-1:0] v);
        mag = v[DB-1] ? DB'(-v) : DB'(v);
    endfunction

    logic [DB-1:0] r_cm, r_a1m, r_a2m;
    logic [SB-1:0] r_sd;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cm  <= mag(c);
            r_a1m <= mag(a1);
            r_a2m <= mag(a2);
            r_sd  <= {sign_ok(a2, c) && sign_ok(o12, c) && sign_ok(o20, c),
                      c == '0, a1[DB-1] ^ c[DB-1], a2[DB-1] ^ c[DB-1], 2'b00};
        end
    end

    logic [NB-1:0] rem1 [NB+1];
    logic [NB-1:0] num1 [NB+1];
    logic [NB-1:0] rem2 [NB+1];
    logic [NB-1:0] num2 [NB+1];
    logic [DB-1:0] den1 [NB+1];
    logic [DB-1:0] den2 [NB+1];
    logic [SB-1:0] sd1  [NB+1];
    logic [SB-1:0] sd2  [NB+1];

    assign rem1[0] = '0;
    assign rem2[0] = '0;
    assign num1[0] = {r_a1m, {FRAC_BITS{1'b0}}};
    assign num2[0] = {r_a2m, {FRAC_BITS{1'b0}}};
    assign den1[0] = r_cm;
    assign den2[0] = r_cm;
    assign sd1[0]  = r_sd;
    assign sd2[0]  = '0;

    for (genvar g = 0; g < NB; g++) begin : g_div
        tpq_div_cell #(.NB(NB), .DB(DB), .SB(SB)) u_c1 (
            .i_clk(i_clk), .i_en(adv),
            .i_rem(rem1[g]), .i_num(num1[g]), .i_den(den1[g]), .i_side(sd1[g]),
            .o_rem(rem1[g+1]), .o_num(num1[g+1]), .o_den(den1[g+1]),
            .o_side(sd1[g+1]));
        tpq_div_cell #(.NB(NB), .DB(DB), .SB(SB)) u_c2 (
            .i_clk(i_clk), .i_en(adv),
            .i_rem(rem2[g]), .i_num(num2[g]), .i_den(den2[g]), .i_side(sd2[g]),
            .o_rem(rem2[g+1]), .o_num(num2[g+1]), .o_den(den2[g+1]),
            .o_side(sd2[g+1]));
    end

    // final stage: signs, first weight, area clamp, saturation
    logic [SB-1:0] sdf;
    logic signed [NB+1:0] w1, w2, w0;
    assign sdf = sd1[NB];
    always_comb begin
        w1 = sdf[3] ? -$signed({2'b00, num1[NB]}) : $signed({2'b00, num1[NB]});
        w2 = sdf[2] ? -$signed({2'b00, num2[NB]}) : $signed({2'b00, num2[NB]});
        if (sdf[4]) begin
            w1 = '0;
            w2 = '0;
        end
        w0 = $signed((NB+2)'(1) << FRAC_BITS) - w1 - w2;
        if (sdf[4]) w0 = '0;
    end

    function automatic logic [WB-1:0] sat(logic signed [NB+1:0] v);
        logic signed [NB+1:0] hi, lo;
        begin
            hi = (NB+2)'((1 << (WB-1)) - 1);
            lo = -hi - (NB+2)'(1);
            if (v > hi) sat = WB'(hi);
            else if (v < lo) sat = WB'(lo);
            else sat = WB'(v);
        end
    endfunction

    logic [AB-1:0] area;
    always_comb begin
        if (DB > AB && (den1[NB] >> AB) != '0) area = '1;
        else area = AB'(den1[NB]);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_out_item.inside_res    <= sdf[5];
            o_out_item.degenerate    <= sdf[4];
            o_out_item.weight_first  <= sat(w0);
            o_out_item.weight_second <= sat(w1);
            o_out_item.weight_third  <= sat(w2);
            o_out_item.double_area   <= area;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed under stall");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output stall");
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.degenerate |->
        o_out_item.weight_first == '0 && o_out_item.double_area == '0)
        else $error("degenerate item with nonzero result");

endmodule

>>> tb/sv/triangle_point_query_tb.sv
module triangle_point_query_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = 2 * 12 + 16 + 2 + 4;
    localparam int CycleLimit = 400000;

    class result_scoreboard;
        tpq_pkg::t_out_item pending[$];
        int errors;
        logic signed [11:0] vert_x[3];
        logic signed [11:0] vert_y[3];

        function new();
            errors = 0;
            foreach (vert_x[i]) begin
                vert_x[i] = '0;
                vert_y[i] = '0;
            end
        endfunction

        function void set_reg(logic [tpq_pkg::CfgIdxBits-1:0] idx, logic [11:0] val);
            if (idx < 6) begin
                if (idx[0]) begin
                    vert_y[idx >> 1] = val;
                end else begin
                    vert_x[idx >> 1] = val;
                end
            end
        endfunction

        function longint orient(longint ax, longint ay, longint bx, longint by);
            return ax * by - ay * bx;
        endfunction

        function int sgn(longint a);
            return (a > 0) - (a < 0);
        endfunction

        function logic [19:0] sat20(longint a);
            if (a > 524287) return 20'sd524287;
            if (a < -524288) return 20'h80000;
            return a[19:0];
        endfunction

        function void note_query(tpq_pkg::t_in_item q);
            tpq_pkg::t_out_item r;
            longint px[3], py[3], qx, qy, c, w0, w1, w2, ar;
            int tri_s, s[3];
            bit ok;
            for (int i = 0; i < 3; i++) begin
                px[i] = vert_x[i];
                py[i] = vert_y[i];
            end
            qx = q.query_x;
            qy = q.query_y;
            c = orient(px[1] - px[0], py[1] - py[0], px[2] - px[0], py[2] - py[0]);
            tri_s = sgn(c);
            ok = 1;
            for (int i = 0; i < 3; i++) begin
                s[i] = sgn(orient(px[(i + 1) % 3] - px[i], py[(i + 1) % 3] - py[i],
                                  qx - px[i], qy - py[i]));
                if (!(s[i] == tri_s || s[i] == 0)) ok = 0;
            end
            w0 = 0; w1 = 0; w2 = 0;
            if (c != 0) begin
                w1 = (orient(qx - px[0], qy - py[0], px[2] - px[0], py[2] - py[0])
                      * 65536) / c;
                w2 = (orient(px[1] - px[0], py[1] - py[0], qx - px[0], qy - py[0])
                      * 65536) / c;
                w0 = 65536 - w1 - w2;
            end
            ar = (c < 0) ? -c : c;
            if (ar > 33554431) ar = 33554431;
            r.inside_res = ok;
            r.weight_first = sat20(w0);
            r.weight_second = sat20(w1);
            r.weight_third = sat20(w2);
            r.double_area = ar[24:0];
            r.degenerate = (c == 0);
            pending.push_back(r);
        endfunction

        function void check_result(tpq_pkg::t_out_item got);
            tpq_pkg::t_out_item e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.inside_res !== e.inside_res) begin
                $display("%0t: inside exp %0d got %0d", $time, e.inside_res, got.inside_res);
                errors++;
            end
            if (got.weight_first !== e.weight_first) begin
                $display("%0t: weight_first exp %0d got %0d", $time,
                         e.weight_first, got.weight_first);
                errors++;
            end
            if (got.weight_second !== e.weight_second) begin
                $display("%0t: weight_second exp %0d got %0d", $time,
                         e.weight_second, got.weight_second);
                errors++;
            end
            if (got.weight_third !== e.weight_third) begin
                $display("%0t: weight_third exp %0d got %0d", $time,
                         e.weight_third, got.weight_third);
                errors++;
            end
            if (got.double_area !== e.double_area) begin
                $display("%0t: double_area exp %0d got %0d", $time,
                         e.double_area, got.double_area);
                errors++;
            end
            if (got.degenerate !== e.degenerate) begin
                $display("%0t: degenerate exp %0d got %0d", $time,
                         e.degenerate, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [tpq_pkg::CfgIdxBits-1:0] i_cfg_idx = '0;
    logic [tpq_pkg::CfgDataBits-1:0] i_cfg_data = '0;
    logic i_in_valid = 0;
    logic o_in_stall;
    tpq_pkg::t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 0;
    tpq_pkg::t_out_item o_out_item;

    result_scoreboard sb = new();
    int cycles = 0;
    bit hold_off = 0;
    bit steady_rx = 0;

    triangle_point_query dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_query(i_in_item);
    end

    int stall_run = 0;
    bit stall_mode = 0;
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_out_stall <= 1;
        end else if (steady_rx) begin
            i_out_stall <= 0;
        end else begin
            if (stall_run == 0) begin
                stall_mode = !stall_mode;
                stall_run = stall_mode ? $urandom_range(1, 6) : $urandom_range(1, 30);
            end
            stall_run--;
            i_out_stall <= stall_mode && ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(logic [tpq_pkg::CfgIdxBits-1:0] idx, logic [11:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 0;
    endtask

    task automatic set_triangle(logic [11:0] ax, ay, bx, by, cx, cy);
        write_reg(tpq_pkg::REG_V0X, ax);
        write_reg(tpq_pkg::REG_V0Y, ay);
        write_reg(tpq_pkg::REG_V1X, bx);
        write_reg(tpq_pkg::REG_V1Y, by);
        write_reg(tpq_pkg::REG_V2X, cx);
        write_reg(tpq_pkg::REG_V2Y, cy);
        write_reg(3'd6, 12'($urandom));
        write_reg(3'd7, 12'($urandom));
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    task automatic send_query(logic [11:0] x, logic [11:0] y);
        i_in_valid <= 1;
        i_in_item <= '{query_x: x, query_y: y};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        i_in_valid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge i_clk);
    endtask

    task automatic random_burst(int n, bit near);
        int left;
        left = n;
        while (left > 0) begin
            int len;
            len = $urandom_range(1, 20);
            for (int k = 0; k < len && left > 0; k++, left--) begin
                if (near)
                    send_query(12'(sb.vert_x[$urandom_range(0, 2)]
                                   + $urandom_range(0, 64) - 32),
                               12'(sb.vert_y[$urandom_range(0, 2)]
                                   + $urandom_range(0, 64) - 32));
                else
                    send_query(12'($urandom), 12'($urandom));
            end
            if ($urandom_range(0, 3) != 0) idle_gap();
        end
        i_in_valid <= 0;
    endtask

    initial begin
        logic signed [11:0] ext[4];
        ext = '{12'h800, 12'h7ff, 12'h000, 12'hfff};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        steady_rx = 1;
        send_query(12'h123, 12'h456);
        i_in_valid <= 0;
        drain();
        steady_rx = 0;

        set_triangle(12'h000, 12'h000, 12'h064, 12'h000, 12'h000, 12'h064);
        foreach (ext[i]) foreach (ext[j]) send_query(ext[i], ext[j]);
        send_query(12'h032, 12'h000);
        send_query(12'h000, 12'h000);
        send_query(12'h032, 12'h032);
        send_query(12'h00a, 12'h00a);
        i_in_valid <= 0;
        drain();

        set_triangle(12'h800, 12'h800, 12'h7ff, 12'h800, 12'h800, 12'h7ff);
        send_query(12'h000, 12'h000);
        send_query(12'h7ff, 12'h7ff);
        send_query(12'h800, 12'h7ff);
        i_in_valid <= 0;
        drain();
        set_triangle(12'h000, 12'h000, 12'h00a, 12'h00a, 12'h014, 12'h014);
        send_query(12'h005, 12'h005);
        send_query(12'hfff, 12'hfff);
        send_query(12'h005, 12'h006);
        i_in_valid <= 0;
        drain();
        set_triangle(12'h010, 12'h020, 12'h010, 12'h020, 12'h010, 12'h020);
        send_query(12'h010, 12'h020);
        send_query(12'h011, 12'h020);
        i_in_valid <= 0;
        drain();

        for (int p = 0; p < 9; p++) begin
            if (p == 0)
                set_triangle(12'h7ff, 12'h800, 12'h800, 12'h7ff, 12'h7ff, 12'h7ff);
            else if (p == 1)
                set_triangle(12'h000, 12'h000, 12'h001, 12'h000, 12'h000, 12'h001);
            else
                set_triangle(12'($urandom), 12'($urandom), 12'($urandom),
                             12'($urandom), 12'($urandom), 12'($urandom));
            if (p == 3) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (200) @(posedge i_clk);
                        hold_off = 0;
                    end
                    random_burst(150, 0);
                join
            end else begin
                random_burst(75, 0);
                random_burst(75, 1);
            end
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
